// ===== src/tsl_pkg.sv =====
// Package with the shared types and constants of the triangle strip assembler.
`default_nettype none

package tsl_pkg;

    localparam int VERTEX_W = 32;

    // Vertices seen in the current strip, saturating at two.
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    typedef logic [VERTEX_W-1:0] vertex_idx_t;

    typedef struct packed {
        vertex_idx_t vertex_index;
        logic        strip_last;
    } tsl_vertex_t;

    typedef struct packed {
        vertex_idx_t corner_a;
        vertex_idx_t corner_b;
        vertex_idx_t corner_c;
        logic        short_strip_error;
    } tsl_result_t;

    // Handshake between the assembler and the result register.
    typedef struct packed {
        logic step;
        logic emit;
    } tsl_ctrl_t;

endpackage

`default_nettype wire

// ===== src/tsl_if.sv =====
// Valid/ready channel interfaces for vertex requests and triangle results.
`default_nettype none

interface tsl_vertex_if;
    logic                      valid;
    logic                      ready;
    logic [tsl_pkg::VERTEX_W-1:0] vertex_index;
    logic                      strip_last;

    modport source (output valid, output vertex_index, output strip_last, input ready);
    modport sink (input valid, input vertex_index, input strip_last, output ready);
endinterface

interface tsl_triangle_if;
    logic                      valid;
    logic                      ready;
    logic [tsl_pkg::VERTEX_W-1:0] corner_a;
    logic [tsl_pkg::VERTEX_W-1:0] corner_b;
    logic [tsl_pkg::VERTEX_W-1:0] corner_c;
    logic                      short_strip_error;

    modport source (output valid, output corner_a, output corner_b, output corner_c,
                    output short_strip_error, input ready);
    modport sink (input valid, input corner_a, input corner_b, input corner_c,
                  input short_strip_error, output ready);
endinterface

`default_nettype wire

// ===== src/tsl_in_stage.sv =====
// Input register that holds one accepted vertex request.
`default_nettype none

module tsl_in_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire tsl_pkg::tsl_vertex_t in_data,
    input  wire logic                 advance,
    output logic                      held_valid,
    output tsl_pkg::tsl_vertex_t      held_data
);
    import tsl_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    tsl_vertex_t data_reg;
    logic        accept;

    // The held request moves on in the same cycle as a new one arrives.
    assign in_ready = !valid_reg || advance;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= in_data;
        end
    end

    assign held_valid = valid_reg;
    assign held_data  = data_reg;

endmodule

`default_nettype wire

// ===== src/tsl_assembler.sv =====
// Strip state and triangle assembly for one vertex per step.
`default_nettype none

module tsl_assembler #(
    parameter int CONNECTOR_VERTICES = 2
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire tsl_pkg::tsl_vertex_t cur,
    input  wire logic                 flat_first_mode,
    output logic                      emit,
    output tsl_pkg::tsl_result_t      result
);
    import tsl_pkg::*;

    localparam logic [1:0] CONN_LOAD = 2'(CONNECTOR_VERTICES % 4);

    vertex_idx_t older_reg, older_next;
    vertex_idx_t newer_reg, newer_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        odd_reg, odd_next;
    logic [1:0]  conn_reg, conn_next;
    logic        distinct;

    assign distinct = (older_reg != newer_reg) && (older_reg != cur.vertex_index)
                      && (newer_reg != cur.vertex_index);

    always_comb
    begin
        older_next = older_reg;
        newer_next = newer_reg;
        cnt_next   = cnt_reg;
        odd_next   = odd_reg;
        conn_next  = conn_reg;
        emit       = 1'b0;
        result     = '0;
        if (conn_reg != 2'd0)
        begin
            conn_next = conn_reg - 2'd1;
            if (cur.strip_last)
            begin
                emit                     = 1'b1;
                result.short_strip_error = 1'b1;
            end
        end
        else
        begin
            case (cnt_reg)
                CNT_NONE:
                begin
                    older_next = cur.vertex_index;
                    cnt_next   = CNT_ONE;
                    if (cur.strip_last)
                    begin
                        emit                     = 1'b1;
                        result.short_strip_error = 1'b1;
                    end
                end
                CNT_ONE:
                begin
                    newer_next = cur.vertex_index;
                    cnt_next   = CNT_TWO;
                end
                default:
                begin
                    emit = distinct;
                    if (!odd_reg)
                    begin
                        result.corner_a = older_reg;
                        result.corner_b = newer_reg;
                        result.corner_c = cur.vertex_index;
                    end
                    else if (flat_first_mode)
                    begin
                        result.corner_a = older_reg;
                        result.corner_b = cur.vertex_index;
                        result.corner_c = newer_reg;
                    end
                    else
                    begin
                        result.corner_a = newer_reg;
                        result.corner_b = older_reg;
                        result.corner_c = cur.vertex_index;
                    end
                    odd_next   = !odd_reg;
                    older_next = newer_reg;
                    newer_next = cur.vertex_index;
                end
            endcase
        end
        // The end of a strip clears the count and winding and arms the connector skip.
        if (cur.strip_last)
        begin
            cnt_next  = CNT_NONE;
            odd_next  = 1'b0;
            conn_next = CONN_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg <= '0;
            newer_reg <= '0;
            cnt_reg   <= CNT_NONE;
            odd_reg   <= 1'b0;
            conn_reg  <= 2'd0;
        end
        else if (step)
        begin
            older_reg <= older_next;
            newer_reg <= newer_next;
            cnt_reg   <= cnt_next;
            odd_reg   <= odd_next;
            conn_reg  <= conn_next;
        end
    end

`ifndef SYNTHESIS
    a_strip_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && cur.strip_last |=> cnt_reg == CNT_NONE && !odd_reg && conn_reg == CONN_LOAD)
        else $error("strip end did not reset the strip state");
    a_odd_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
        odd_reg |-> cnt_reg == CNT_TWO)
        else $error("winding flag set before two vertices were seen");
    a_skip_outside_strip: assert property (@(posedge clk) disable iff (!rst_n)
        conn_reg != 2'd0 |-> cnt_reg == CNT_NONE)
        else $error("connector skip pending inside a strip");
    a_error_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        emit && result.short_strip_error |-> cur.strip_last)
        else $error("error result without a strip end");
`endif

endmodule

`default_nettype wire

// ===== src/tsl_out_stage.sv =====
// Result register that holds one triangle or error result until it is taken.
`default_nettype none

module tsl_out_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tsl_pkg::tsl_ctrl_t   ctrl,
    input  wire tsl_pkg::tsl_result_t res_in,
    output logic                      free,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output tsl_pkg::tsl_result_t      res_out
);
    import tsl_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    tsl_result_t res_reg;
    logic        load;

    assign free = !valid_reg || out_ready;
    assign load = ctrl.step && ctrl.emit;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("result register loaded while a result was still waiting");
    a_error_zero_corners: assert property (@(posedge clk) disable iff (!rst_n)
        load && res_in.short_strip_error |-> res_in.corner_a == '0
            && res_in.corner_b == '0 && res_in.corner_c == '0)
        else $error("error result carries vertex indices");
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid)
        else $error("loaded result not offered");
`endif

endmodule

`default_nettype wire

// ===== src/tristrip_to_triangle_list.sv =====
// Top level of the triangle strip to triangle list assembler.
`default_nettype none

//  Channel     Direction  Carries
//  ---------   ---------  ------------------------------------------------
//  vertices    in         vertex_index (32), strip_last (1)
//  triangles   out        corner_a/b/c (32 each), short_strip_error (1)
//  cfg         in         cfg_we, cfg_wdata: flat_first_mode (1)
//
//  Each vertex request passes through the input register, then through the
//  assembly compares into the result register. A new request is accepted
//  every cycle as long as the result register is free; the throughput is set by the
//  single state update in the assembler, which handles one vertex per clock.
//  Reset clears the strip state, the mode register and both valid flags.
//  A stalled result holds the result register; the input register still takes
//  one further request if it is empty, after which the input side waits.

module tristrip_to_triangle_list #(
    parameter int CONNECTOR_VERTICES = 2
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    tsl_vertex_if.sink     vertices,
    tsl_triangle_if.source triangles,
    input  wire logic      cfg_we,
    input  wire logic      cfg_wdata
);
    import tsl_pkg::*;

    // Configuration: provoking-vertex placement for odd (swapped) triangles.
    logic flat_first_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flat_first_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            flat_first_mode_reg <= cfg_wdata;
        end
    end

    tsl_vertex_t in_data;
    tsl_vertex_t held_data;
    logic        held_valid;
    logic        out_free;
    logic        emit;
    tsl_result_t asm_result;
    tsl_result_t out_result;
    tsl_ctrl_t   ctrl;

    assign in_data.vertex_index = vertices.vertex_index;
    assign in_data.strip_last   = vertices.strip_last;

    // A held vertex is processed whenever the result register can take a
    // result, whether or not this vertex produces one.
    assign ctrl.step = held_valid && out_free;
    assign ctrl.emit = emit;

    tsl_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (vertices.valid),
        .in_ready   (vertices.ready),
        .in_data    (in_data),
        .advance    (ctrl.step),
        .held_valid (held_valid),
        .held_data  (held_data)
    );

    tsl_assembler #(
        .CONNECTOR_VERTICES (CONNECTOR_VERTICES)
    ) u_assembler (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (ctrl.step),
        .cur             (held_data),
        .flat_first_mode (flat_first_mode_reg),
        .emit            (emit),
        .result          (asm_result)
    );

    tsl_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .res_in    (asm_result),
        .free      (out_free),
        .out_valid (triangles.valid),
        .out_ready (triangles.ready),
        .res_out   (out_result)
    );

    assign triangles.corner_a          = out_result.corner_a;
    assign triangles.corner_b          = out_result.corner_b;
    assign triangles.corner_c          = out_result.corner_c;
    assign triangles.short_strip_error = out_result.short_strip_error;

endmodule

`default_nettype wire

// ===== test/tsl_checker.sv =====
// Checker that predicts and compares the triangles of the strip assembler.
`timescale 1ns / 100ps

module tsl_checker #(
    parameter int CONNECTOR_VERTICES = 2
) (
    input  logic    clk,
    input  logic    rst_n,
    tsl_vertex_if   vertices,
    tsl_triangle_if triangles,
    input  logic    cfg_we,
    input  logic    cfg_wdata,
    output int      failures,
    output int      results_pending
);

    import tsl_pkg::*;

    localparam logic [1:0] FILL_TWO         = 2'd2;
    localparam logic [1:0] CONNECTOR_RELOAD = 2'(CONNECTOR_VERTICES % 4);

    vertex_idx_t older_seen;
    vertex_idx_t newer_seen;
    logic [1:0]  strip_fill;
    logic        odd_winding;
    logic [1:0]  skip_left;
    logic        flat_first;
    tsl_result_t triangles_due[$];
    int          mismatch_count = 0;

    assign failures = mismatch_count;

    function automatic void close_strip();
        strip_fill  = CNT_NONE;
        odd_winding = 1'b0;
        skip_left   = CONNECTOR_RELOAD;
    endfunction

    // Advances the strip state by one vertex; returns 1 when a triangle or an
    // error comes out of it.
    function automatic logic assemble_vertex(input vertex_idx_t v, input logic last,
                                             output tsl_result_t triangle);
        vertex_idx_t v0;
        vertex_idx_t v1;
        logic        emits;
        triangle = '0;
        emits    = 1'b0;
        if (skip_left != 2'd0)
        begin
            skip_left = skip_left - 2'd1;
            if (last)
            begin
                close_strip();
                emits = 1'b1;
                triangle.short_strip_error = 1'b1;
            end
        end
        else if (strip_fill == CNT_NONE)
        begin
            older_seen = v;
            strip_fill = CNT_ONE;
            if (last)
            begin
                close_strip();
                emits = 1'b1;
                triangle.short_strip_error = 1'b1;
            end
        end
        else if (strip_fill == CNT_ONE)
        begin
            newer_seen = v;
            strip_fill = FILL_TWO;
            if (last)
                close_strip();
        end
        else
        begin
            v0 = older_seen;
            v1 = newer_seen;
            if (v0 != v1 && v0 != v && v1 != v)
            begin
                emits = 1'b1;
                if (!odd_winding)
                begin
                    triangle.corner_a = v0;
                    triangle.corner_b = v1;
                    triangle.corner_c = v;
                end
                else if (flat_first)
                begin
                    triangle.corner_a = v0;
                    triangle.corner_b = v;
                    triangle.corner_c = v1;
                end
                else
                begin
                    triangle.corner_a = v1;
                    triangle.corner_b = v0;
                    triangle.corner_c = v;
                end
            end
            odd_winding = !odd_winding;
            older_seen  = v1;
            newer_seen  = v;
            if (last)
                close_strip();
        end
        return emits;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tsl_result_t triangle;
        tsl_result_t due;
        if (!rst_n)
        begin
            older_seen  = '0;
            newer_seen  = '0;
            strip_fill  = CNT_NONE;
            odd_winding = 1'b0;
            skip_left   = 2'd0;
            flat_first  = 1'b0;
            triangles_due.delete();
            results_pending <= 0;
        end
        else
        begin
            // A result leaving at this edge belongs to an earlier request, so
            // it is matched before the request of this edge is predicted.
            if (triangles.valid && triangles.ready)
            begin
                if (triangles_due.size() == 0)
                begin
                    $display("%0t: unexpected triangle %h %h %h err %b", $time,
                             triangles.corner_a, triangles.corner_b,
                             triangles.corner_c, triangles.short_strip_error);
                    mismatch_count++;
                end
                else
                begin
                    due = triangles_due.pop_front();
                    if (due.corner_a !== triangles.corner_a
                        || due.corner_b !== triangles.corner_b
                        || due.corner_c !== triangles.corner_c
                        || due.short_strip_error !== triangles.short_strip_error)
                    begin
                        $display("%0t: expected %h %h %h err %b, actual %h %h %h err %b",
                                 $time, due.corner_a, due.corner_b, due.corner_c,
                                 due.short_strip_error, triangles.corner_a,
                                 triangles.corner_b, triangles.corner_c,
                                 triangles.short_strip_error);
                        mismatch_count++;
                    end
                end
            end
            if (vertices.valid && vertices.ready)
            begin
                if (assemble_vertex(vertices.vertex_index, vertices.strip_last, triangle))
                    triangles_due.push_back(triangle);
            end
            if (cfg_we)
                flat_first = cfg_wdata;
            results_pending <= triangles_due.size();
        end
    end

endmodule

// ===== test/tristrip_to_triangle_list_test.sv =====
// Testbench top that drives vertex requests into the strip assembler.
`timescale 1ns / 100ps

module tristrip_to_triangle_list_test;

    import tsl_pkg::*;

    // The connector count must agree with the block, since the stimulus
    // inserts this many connector vertices between strips unless a strip end falls among them.
    localparam int CONNECTORS      = 2;
    // Length of the deliberate hold-off on the result side, in cycles.
    localparam int HOLD_OFF_CYCLES = 64;
    // Cycles allowed after the last expected triangle for a request that
    // yields nothing to leave the two-stage pipeline.
    localparam int DRAIN_CYCLES    = 4;
    // Cycles without any handshake before the run is declared hung.
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 180;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    int   sender_idle_pct;
    int   receiver_stall_pct;
    bit   hold_off_request;
    bit   connectors_due;
    int   failures;
    int   results_pending;
    int   quiet_cycles;

    tsl_vertex_if   vertices();
    tsl_triangle_if triangles();

    tristrip_to_triangle_list #(
        .CONNECTOR_VERTICES(CONNECTORS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .vertices (vertices),
        .triangles(triangles),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    tsl_checker #(
        .CONNECTOR_VERTICES(CONNECTORS)
    ) triangle_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .vertices       (vertices),
        .triangles      (triangles),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .failures       (failures),
        .results_pending(results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit take_chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Result side. Normally ready follows the stall percentage of the current
    // phase; when a hold-off is requested it stays low for a long, counted
    // stretch so that the block backs up and refuses further requests.
    initial
    begin
        triangles.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                triangles.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
                hold_off_request = 1'b0;
            end
            else
                triangles.ready <= !take_chance(receiver_stall_pct);
        end
    end

    // Watchdog: counts cycles in which neither channel completes a handshake.
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((vertices.valid && vertices.ready) || (triangles.valid && triangles.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Offers one vertex request and returns at the edge that accepts it.
    // Valid is left high so that a following request can go out back to back;
    // it is lowered when the next call decides to idle or when the results are drained.
    task automatic offer_vertex(input vertex_idx_t v, input logic last);
        while (take_chance(sender_idle_pct))
        begin
            vertices.valid <= 1'b0;
            @(posedge clk);
        end
        vertices.valid        <= 1'b1;
        vertices.vertex_index <= v;
        vertices.strip_last   <= last;
        @(posedge clk);
        while (!vertices.ready) @(posedge clk);
        // Any strip end, including one on a connector, makes the block skip
        // a fresh set of connectors.
        if (last)
            connectors_due = 1'b1;
    endtask

    // Pool 0 draws full-width indices, pool 1 a handful of small ones so that
    // degenerate triangles are common, pool 2 the corner values of the range.
    function automatic vertex_idx_t pick_vertex(int pool);
        vertex_idx_t v;
        if (pool == 0)
            v = $urandom;
        else if (pool == 1)
            v = $urandom_range(0, 4);
        else
        begin
            case ($urandom_range(0, 4))
                0:       v = 32'h0000_0000;
                1:       v = 32'hFFFF_FFFF;
                2:       v = 32'h0000_0001;
                3:       v = 32'h7FFF_FFFF;
                default: v = 32'h8000_0000;
            endcase
        end
        return v;
    endfunction

    // Sends the connectors due, then one strip. Most strips are well formed
    // with three or more vertices; a few have one vertex or break off inside the
    // connectors, which the block reports as errors, and a few have two, which stay silent.
    task automatic send_random_strip(inout int sent);
        int length;
        int pool;
        int roll;
        int k;
        if (connectors_due)
        begin
            for (k = 0; k < CONNECTORS; k++)
            begin
                if (take_chance(4))
                begin
                    offer_vertex($urandom, 1'b1);
                    sent++;
                    return;
                end
                offer_vertex($urandom, 1'b0);
                sent++;
            end
            connectors_due = 1'b0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 6)
            length = 1;
        else if (roll < 12)
            length = 2;
        else if (roll < 16)
            length = $urandom_range(13, 40);
        else
            length = $urandom_range(3, 12);
        pool = $urandom_range(0, 2);
        for (k = 1; k <= length; k++)
        begin
            offer_vertex(pick_vertex(pool), k == length);
            sent++;
        end
    endtask

    // Stops offering and waits until every expected triangle has been taken,
    // then lets the pipeline empty of requests that yield nothing.
    task automatic drain_results();
        vertices.valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_flat_first(input logic mode);
        drain_results();
        cfg_wdata <= mode;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int phase;
        int sent;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = 1'b0;
        vertices.valid        = 1'b0;
        vertices.vertex_index = '0;
        vertices.strip_last   = 1'b0;
        sender_idle_pct       = 0;
        receiver_stall_pct    = 0;
        hold_off_request      = 1'b0;
        connectors_due        = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the mode still at its reset value. The first
        // strip has no connectors. It carries the extremes of the index and
        // ends on a degenerate triangle that must be dropped.
        offer_vertex(32'h0000_0000, 1'b0);
        offer_vertex(32'hFFFF_FFFF, 1'b0);
        offer_vertex(32'h0000_0001, 1'b0);
        offer_vertex(32'hFFFF_FFFE, 1'b0);
        offer_vertex(32'h0000_0001, 1'b1);
        // Connectors, then a strip that ends on its first vertex: an error.
        offer_vertex(32'h0000_0007, 1'b0);
        offer_vertex(32'h0000_0008, 1'b0);
        offer_vertex(32'h0000_0005, 1'b1);
        // Connectors, then a strip of two vertices, which is valid but silent.
        offer_vertex(32'h0000_0009, 1'b0);
        offer_vertex(32'h0000_0009, 1'b0);
        offer_vertex(32'h0000_000A, 1'b0);
        offer_vertex(32'h0000_000B, 1'b1);
        // A strip end on the first connector is an error and reloads the skip.
        offer_vertex(32'h0000_0003, 1'b1);
        // The second connector position breaking off as well.
        offer_vertex(32'h0000_0004, 1'b0);
        offer_vertex(32'h0000_0006, 1'b1);
        offer_vertex(32'h0000_0000, 1'b0);
        offer_vertex(32'h0000_0000, 1'b0);
        // A full strip with alternating bit patterns and both windings.
        offer_vertex(32'hAAAA_AAAA, 1'b0);
        offer_vertex(32'h5555_5555, 1'b0);
        offer_vertex(32'h1234_5678, 1'b0);
        offer_vertex(32'h8000_0000, 1'b0);
        offer_vertex(32'h7FFF_FFFF, 1'b1);
        connectors_due = 1'b1;

        // Random part. Each phase pairs one idling pattern with one mode, so
        // that both modes meet every pattern. The phases with no idling also
        // hold the result side off for a long stretch to fill the block.
        for (phase = 0; phase < PHASES; phase++)
        begin
            write_flat_first(1'((phase ^ (phase >> 2)) & 1));
            case (phase % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                    hold_off_request   = 1'b1;
                end
                1:
                begin
                    sender_idle_pct    = 51;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 51;
                end
                default:
                begin
                    sender_idle_pct    = 13;
                    receiver_stall_pct = 13;
                end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
                send_random_strip(sent);
        end

        drain_results();
        if (failures == 0 && results_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
